// ===== src/frame_interval_window_stats_assert.svh =====
// Assertion macros for the frame interval statistics block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef FRAME_INTERVAL_WINDOW_STATS_ASSERT_SVH
`define FRAME_INTERVAL_WINDOW_STATS_ASSERT_SVH

// Same-cycle implication.
`define FIWS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fiws: implication check failed");

// Next-cycle implication.
`define FIWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fiws: next-cycle check failed");

`endif

// ===== src/fiws_pkg.sv =====
// Shared types and constants for the frame interval statistics block.
// No dependencies.
`default_nettype none

package fiws_pkg;

  localparam int TIME_BITS = 48;
  localparam int IVL_BITS  = 24;
  localparam int SUM_BITS  = IVL_BITS + 1;
  localparam int GEN_BITS  = 32;
  localparam int CFG_BITS  = 24;
  localparam int CNT_BITS  = $clog2(TIME_BITS);
  localparam int DCNT_BITS = $clog2(SUM_BITS);

  localparam logic [IVL_BITS-1:0] IVL_MAX = {IVL_BITS{1'b1}};
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  localparam logic [CFG_BITS-1:0] WINDOW_RST  = CFG_BITS'(500000);
  localparam logic [CFG_BITS-1:0] MAX_IVL_RST = CFG_BITS'(10000000);

  typedef enum logic [0:0] {
    REG_WINDOW  = 1'b0,
    REG_MAX_IVL = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [TIME_BITS-1:0] now_us;
    logic [GEN_BITS-1:0]  pause_generation;
  } in_item_t;

  typedef struct packed {
    logic [IVL_BITS-1:0] avg_interval_us;
    logic [IVL_BITS-1:0] min_interval_us;
    logic [IVL_BITS-1:0] max_interval_out_us;
    logic                stats_ready;
    logic                interval_accepted;
  } out_item_t;

  typedef struct packed {
    logic                start;
    logic [SUM_BITS-1:0] dividend;
    logic [IVL_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [SUM_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== src/fiws_in_if.sv =====
// Input channel: valid/ready handshake carrying one frame event item.
// Depends on fiws_pkg.
`default_nettype none

interface fiws_in_if;
  logic               valid;
  logic               ready;
  fiws_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/fiws_out_if.sv =====
// Output channel: valid/ready handshake carrying one statistics item.
// Depends on fiws_pkg.
`default_nettype none

interface fiws_out_if;
  logic                valid;
  logic                ready;
  fiws_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/fiws_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on fiws_pkg.
`default_nettype none

module fiws_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fiws_pkg::div_req_t req_i,
  output      fiws_pkg::div_rsp_t rsp_o
);

  logic                               run_q;
  logic                               done_q;
  logic [fiws_pkg::DCNT_BITS-1:0]     cnt_q;
  logic [fiws_pkg::IVL_BITS-1:0]      rem_q;
  logic [fiws_pkg::SUM_BITS-1:0]      quo_q;
  logic [fiws_pkg::IVL_BITS:0]        trial;
  logic [fiws_pkg::IVL_BITS-1:0]      div_q;
  logic                               ge;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[fiws_pkg::SUM_BITS-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
        rem_q <= '0;
        quo_q <= req_i.dividend;
        div_q <= req_i.divisor;
      end else if (run_q) begin
        rem_q <= ge ? fiws_pkg::IVL_BITS'(trial - {1'b0, div_q})
                    : trial[fiws_pkg::IVL_BITS-1:0];
        quo_q <= {quo_q[fiws_pkg::SUM_BITS-2:0], ge};
        if (cnt_q == fiws_pkg::DCNT_BITS'(fiws_pkg::SUM_BITS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ===== src/frame_interval_window_stats.sv =====
// Frame interval window statistics, top level.
// Depends on fiws_pkg, fiws_in_if, fiws_out_if, fiws_div and the assertion header.
//
// Usage:
//   in_ch_i  : one frame event item per handshake (now_us, pause_generation).
//   out_ch_o : one statistics item per input item, in order.
//   cfg_*    : write port; index 0 = window_us, index 1 = max_interval_us.
//              Write only while the block is idle.
// Processing:
//   The interval is formed bit-serially, one timestamp bit per cycle, in a
//   subtract-and-compare pass; an accepted interval then updates the window.
//   When a window closes, a bit-serial divider forms the average. The result
//   is registered in the finish state, and ready returns together with it as
//   the block goes back to idle: a new item is taken only once the last is through.
// Reset:
//   All history and shown values clear to zero; registers return to
//   window_us = 500000 and max_interval_us = 10000000.
// Stall:
//   The result sits in an output register until taken. A new item is
//   accepted meanwhile; its result waits in the finish state for the slot.
`default_nettype none

module frame_interval_window_stats (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [fiws_pkg::CFG_BITS-1:0] cfg_data_i,
  fiws_in_if.sink                            in_ch_i,
  fiws_out_if.source                         out_ch_o
);

`include "frame_interval_window_stats_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_UPDATE,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } state_e;

  state_e state_q;

  // configuration
  logic [fiws_pkg::CFG_BITS-1:0] window_q, max_ivl_q;

  // history
  logic [fiws_pkg::TIME_BITS-1:0] last_time_q;
  logic [fiws_pkg::GEN_BITS-1:0]  last_gen_q;
  logic                           has_prev_q;

  // serial subtract / compare
  logic [fiws_pkg::TIME_BITS-1:0] now_sh_q, prev_sh_q, max_sh_q, diff_sh_q;
  logic [fiws_pkg::CNT_BITS-1:0]  cnt_q;
  logic                           borrow_q, gt_q, nz_q, across_q, had_prev_q;
  logic                           acc_q;

  // window and shown values
  logic [fiws_pkg::IVL_BITS-1:0] win_min_q, win_max_q, win_cnt_q;
  logic [fiws_pkg::SUM_BITS-1:0] win_sum_q;
  logic [fiws_pkg::IVL_BITS-1:0] shown_avg_q, shown_min_q, shown_max_q;
  logic                          has_shown_q;

  // output register
  logic                out_valid_q;
  fiws_pkg::out_item_t out_data_q;

  fiws_pkg::div_req_t div_req;
  fiws_pkg::div_rsp_t div_rsp;

  logic                          a_bit, b_bit, m_bit, d_bit, borrow_d;
  logic [fiws_pkg::IVL_BITS-1:0] ivl;
  logic                          accepted;
  logic [fiws_pkg::SUM_BITS:0]   sum_ext;
  logic                          in_take;

  assign in_ch_i.ready = (state_q == ST_IDLE);
  assign in_take       = in_ch_i.valid && in_ch_i.ready;

  // one bit of now - prev per cycle, LSB first
  assign a_bit    = now_sh_q[0];
  assign b_bit    = prev_sh_q[0];
  assign m_bit    = max_sh_q[0];
  assign d_bit    = a_bit ^ b_bit ^ borrow_q;
  assign borrow_d = (~a_bit & b_bit) | (~a_bit & borrow_q) | (b_bit & borrow_q);

  // a previous item must exist; interval must be positive, same pause generation,
  // not above the limit; gt_q also catches any set bit above the interval width
  assign ivl      = diff_sh_q[fiws_pkg::IVL_BITS-1:0];
  assign accepted = had_prev_q && !across_q && !borrow_q && nz_q && !gt_q;
  assign sum_ext  = {1'b0, win_sum_q} + (fiws_pkg::SUM_BITS + 1)'(ivl);

  assign div_req.start    = (state_q == ST_CHECK) && (win_sum_q >= {1'b0, window_q});
  assign div_req.dividend = win_sum_q;
  assign div_req.divisor  = win_cnt_q;

  fiws_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= fiws_pkg::WINDOW_RST;
      max_ivl_q   <= fiws_pkg::MAX_IVL_RST;
      last_time_q <= '0;
      last_gen_q  <= '0;
      has_prev_q  <= 1'b0;
      now_sh_q    <= '0;
      prev_sh_q   <= '0;
      max_sh_q    <= '0;
      diff_sh_q   <= '0;
      cnt_q       <= '0;
      borrow_q    <= 1'b0;
      gt_q        <= 1'b0;
      nz_q        <= 1'b0;
      across_q    <= 1'b0;
      had_prev_q  <= 1'b0;
      acc_q       <= 1'b0;
      win_min_q   <= '0;
      win_max_q   <= '0;
      win_cnt_q   <= '0;
      win_sum_q   <= '0;
      shown_avg_q <= '0;
      shown_min_q <= '0;
      shown_max_q <= '0;
      has_shown_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (fiws_pkg::cfg_reg_e'(cfg_idx_i))
          fiws_pkg::REG_WINDOW:  window_q  <= cfg_data_i;
          fiws_pkg::REG_MAX_IVL: max_ivl_q <= cfg_data_i;
          default: ;
        endcase
      end

      // the finish state refills the slot itself when it is taken
      if (out_valid_q && out_ch_o.ready && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            now_sh_q    <= in_ch_i.data.now_us;
            prev_sh_q   <= last_time_q;
            max_sh_q    <= fiws_pkg::TIME_BITS'(max_ivl_q);
            across_q    <= in_ch_i.data.pause_generation != last_gen_q;
            had_prev_q  <= has_prev_q;
            last_time_q <= in_ch_i.data.now_us;
            last_gen_q  <= in_ch_i.data.pause_generation;
            has_prev_q  <= 1'b1;
            cnt_q       <= '0;
            borrow_q    <= 1'b0;
            gt_q        <= 1'b0;
            nz_q        <= 1'b0;
            state_q     <= ST_SUB;
          end
        end

        ST_SUB: begin
          now_sh_q  <= now_sh_q >> 1;
          prev_sh_q <= prev_sh_q >> 1;
          max_sh_q  <= max_sh_q >> 1;
          diff_sh_q <= {d_bit, diff_sh_q[fiws_pkg::TIME_BITS-1:1]};
          borrow_q  <= borrow_d;
          nz_q      <= nz_q | d_bit;
          if (d_bit != m_bit) begin
            gt_q <= d_bit;
          end
          if (cnt_q == fiws_pkg::CNT_BITS'(fiws_pkg::TIME_BITS - 1)) begin
            state_q <= ST_UPDATE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end

        ST_UPDATE: begin
          acc_q <= accepted;
          if (accepted) begin
            if (win_cnt_q == '0) begin
              win_min_q <= ivl;
              win_max_q <= ivl;
            end else begin
              if (ivl < win_min_q) win_min_q <= ivl;
              if (ivl > win_max_q) win_max_q <= ivl;
            end
            win_sum_q <= sum_ext[fiws_pkg::SUM_BITS] ? fiws_pkg::SUM_MAX
                                                     : sum_ext[fiws_pkg::SUM_BITS-1:0];
            if (win_cnt_q != fiws_pkg::IVL_MAX) begin
              win_cnt_q <= win_cnt_q + 1'b1;
            end
            // first accepted interval seeds the shown values
            if (!has_shown_q) begin
              shown_avg_q <= ivl;
              shown_min_q <= ivl;
              shown_max_q <= ivl;
              has_shown_q <= 1'b1;
            end
            state_q <= ST_CHECK;
          end else begin
            state_q <= ST_FINISH;
          end
        end

        ST_CHECK: begin
          state_q <= div_req.start ? ST_DIV : ST_FINISH;
        end

        ST_DIV: begin
          if (div_rsp.done) begin
            shown_avg_q <= div_rsp.quotient[fiws_pkg::SUM_BITS-1] ? fiws_pkg::IVL_MAX
                           : div_rsp.quotient[fiws_pkg::IVL_BITS-1:0];
            shown_min_q <= win_min_q;
            shown_max_q <= win_max_q;
            win_sum_q   <= '0;
            win_cnt_q   <= '0;
            state_q     <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          if (!out_valid_q || out_ch_o.ready) begin
            out_valid_q                    <= 1'b1;
            out_data_q.avg_interval_us     <= shown_avg_q;
            out_data_q.min_interval_us     <= shown_min_q;
            out_data_q.max_interval_out_us <= shown_max_q;
            out_data_q.stats_ready         <= has_shown_q;
            out_data_q.interval_accepted   <= acc_q;
            state_q                        <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_ch_o.valid = out_valid_q;
  assign out_ch_o.data  = out_data_q;

  `FIWS_ASSERT_IMPLY(a_acc_shown, out_ch_o.valid && out_ch_o.data.interval_accepted, out_ch_o.data.stats_ready)
  `FIWS_ASSERT_IMPLY(a_empty_win, win_cnt_q == '0, win_sum_q == '0)
  `FIWS_ASSERT_IMPLY(a_div_state, div_rsp.done, state_q == ST_DIV)
  `FIWS_ASSERT_NEXT(a_take_sub, in_take, state_q == ST_SUB && has_prev_q)

endmodule

`default_nettype wire
